// File: sv/six_button_pad_multiplex_reader_defines.svh
// ----------------------------------------------------------------------------
// six button pad reader assertion macros
// shared clocking and reset wrappers for the concurrent checks
// ----------------------------------------------------------------------------
`ifndef SIX_BUTTON_PAD_MULTIPLEX_READER_DEFINES_SVH
`define SIX_BUTTON_PAD_MULTIPLEX_READER_DEFINES_SVH

// check sampled on clk, ignored while reset is asserted
`define SBPMR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on clk, also held during reset
`define SBPMR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sbpmr_pkg.sv
// ----------------------------------------------------------------------------
// six button pad reader package
// button bit positions, poll state and result types
// ----------------------------------------------------------------------------
package sbpmr_pkg;

    localparam int WORD_W     = 13;
    localparam int PIN_W      = 6;
    localparam int SKIP_W     = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    localparam int BTN_UP    = 0;
    localparam int BTN_DOWN  = 1;
    localparam int BTN_LEFT  = 2;
    localparam int BTN_RIGHT = 3;
    localparam int BTN_A     = 4;
    localparam int BTN_B     = 5;
    localparam int BTN_C     = 6;
    localparam int BTN_START = 7;
    localparam int BTN_X     = 8;
    localparam int BTN_Y     = 9;
    localparam int BTN_Z     = 10;
    localparam int BTN_MODE  = 11;
    localparam int BTN_HOME  = 12;

    localparam logic [SKIP_W-1:0] SKIP_NONE  = 2'd0;
    localparam logic [SKIP_W-1:0] SKIP_STEPS = 2'd2;

    localparam logic [WORD_W-1:0] WORD_HOME   = 13'h1000;
    localparam logic [WORD_W-1:0] WORD_HOME_Z = 13'h1400;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic              select_high;
        logic              pad_connected;
        logic              six_button_seen;
        logic [SKIP_W-1:0] skip_count;
        word_t             button_word;
        word_t             previous_word;
        logic              remap_active;
    } poll_state_t;

    // select starts high so the first step samples with select low
    localparam poll_state_t STATE_RESET = '{
        select_high:     1'b1,
        pad_connected:   1'b0,
        six_button_seen: 1'b0,
        skip_count:      SKIP_NONE,
        button_word:     '0,
        previous_word:   '0,
        remap_active:    1'b0
    };

    typedef struct packed {
        logic  remap_toggled;
        logic  remap_mode;
        logic  next_select_level;
        logic  select_level;
        word_t final_buttons;
        word_t raw_buttons;
    } poll_result_t;

endpackage

// File: sv/sbpmr_step.sv
// ----------------------------------------------------------------------------
// six button pad reader poll step
// decodes one pin sample against the current poll state
// ----------------------------------------------------------------------------
module sbpmr_step
(
    input  sbpmr_pkg::poll_state_t          cur,
    input  logic [sbpmr_pkg::PIN_W-1:0]     pin_levels,
    input  logic                            report,
    output sbpmr_pkg::poll_state_t          nxt,
    output sbpmr_pkg::poll_result_t         res
);

    logic                 p1, p2, p3, p4, p6, p9;
    logic                 sel;
    logic                 toggle;
    logic                 remap;
    sbpmr_pkg::word_t     w;
    sbpmr_pkg::word_t     fin;

    assign p1 = ~pin_levels[0];
    assign p2 = ~pin_levels[1];
    assign p3 = ~pin_levels[2];
    assign p4 = ~pin_levels[3];
    assign p6 = ~pin_levels[4];
    assign p9 = ~pin_levels[5];

    assign sel = ~cur.select_high;

    always_comb
    begin
        nxt             = cur;
        nxt.select_high = sel;
        w               = cur.button_word;

        if (cur.skip_count == sbpmr_pkg::SKIP_NONE)
        begin
            if (sel)
            begin
                if (cur.pad_connected)
                begin
                    if (cur.six_button_seen)
                    begin
                        w[sbpmr_pkg::BTN_Z]    = p1;
                        w[sbpmr_pkg::BTN_Y]    = p2;
                        w[sbpmr_pkg::BTN_X]    = p3;
                        w[sbpmr_pkg::BTN_MODE] = p4;
                        nxt.six_button_seen    = 1'b0;
                        nxt.skip_count         = sbpmr_pkg::SKIP_STEPS;
                    end
                    else
                    begin
                        w[sbpmr_pkg::BTN_UP]    = p1;
                        w[sbpmr_pkg::BTN_DOWN]  = p2;
                        w[sbpmr_pkg::BTN_LEFT]  = p3;
                        w[sbpmr_pkg::BTN_RIGHT] = p4;
                        w[sbpmr_pkg::BTN_B]     = p6;
                        w[sbpmr_pkg::BTN_C]     = p9;
                    end
                end
                else
                begin
                    // plain two-fire joystick
                    w                       = '0;
                    w[sbpmr_pkg::BTN_UP]    = p1;
                    w[sbpmr_pkg::BTN_DOWN]  = p2;
                    w[sbpmr_pkg::BTN_LEFT]  = p3;
                    w[sbpmr_pkg::BTN_RIGHT] = p4;
                    w[sbpmr_pkg::BTN_A]     = p6;
                    w[sbpmr_pkg::BTN_B]     = p9;
                end
            end
            else
            begin
                nxt.pad_connected   = p3 & p4;
                nxt.six_button_seen = p1 & p2;
                if (p3 && p4 && !(p1 && p2))
                begin
                    w[sbpmr_pkg::BTN_A]     = p6;
                    w[sbpmr_pkg::BTN_START] = p9;
                end
            end
        end
        else
        begin
            if (cur.skip_count == sbpmr_pkg::SKIP_STEPS)
            begin
                w[sbpmr_pkg::BTN_HOME] = p1;
            end
            nxt.skip_count = cur.skip_count - 2'd1;
        end

        nxt.button_word = w;

        toggle = report && (cur.previous_word == sbpmr_pkg::WORD_HOME)
                        && (w == sbpmr_pkg::WORD_HOME_Z);
        remap  = cur.remap_active ^ toggle;
        if (report)
        begin
            nxt.previous_word = w;
        end
        nxt.remap_active = remap;

        fin = w;
        if (remap)
        begin
            fin[sbpmr_pkg::BTN_A] = w[sbpmr_pkg::BTN_B];
            fin[sbpmr_pkg::BTN_B] = w[sbpmr_pkg::BTN_A];
            fin[sbpmr_pkg::BTN_X] = w[sbpmr_pkg::BTN_Y];
            fin[sbpmr_pkg::BTN_Y] = w[sbpmr_pkg::BTN_X];
            if (w[sbpmr_pkg::BTN_HOME])
            begin
                fin[sbpmr_pkg::BTN_DOWN] = 1'b1;
                fin[sbpmr_pkg::BTN_MODE] = 1'b1;
                fin[sbpmr_pkg::BTN_HOME] = 1'b0;
            end
        end

        res.raw_buttons       = w;
        res.final_buttons     = fin;
        res.select_level      = sel;
        res.next_select_level = ~sel;
        res.remap_mode        = remap;
        res.remap_toggled     = toggle;
    end

endmodule

// File: sv/six_button_pad_multiplex_reader.sv
// ----------------------------------------------------------------------------
// six button pad multiplex reader
// Each request on the input stream is one poll step: the select line flips,
// the six active-low pins sampled at that level update a 13-button word, and
// one result leaves on the output stream carrying the raw word, the word
// after the remap swap, the select levels and the remap mode. A step goes
// from the input register through the decode logic into the result register,
// and one step can be accepted every cycle unless a result waits downstream;
// then the input register takes one more step and holds it until the result
// is taken. Writing the configuration channel loads the remap mode directly;
// write it only while no step is in flight.
// ----------------------------------------------------------------------------
`include "six_button_pad_multiplex_reader_defines.svh"

module six_button_pad_multiplex_reader
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [5:0] pin_levels, [6] report, [7] zero
    input  logic [sbpmr_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [12:0] raw_buttons, [25:13] final_buttons, [26] select_level,
    // [27] next_select_level, [28] remap_mode, [29] remap_toggled, [31:30] zero
    output logic [sbpmr_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data
);

    logic                              in_valid_reg;
    logic [sbpmr_pkg::PIN_W-1:0]       in_pins_reg;
    logic                              in_report_reg;
    logic                              out_valid_reg;
    sbpmr_pkg::poll_result_t           out_res_reg;
    sbpmr_pkg::poll_state_t            state_reg;
    sbpmr_pkg::poll_state_t            state_next;
    sbpmr_pkg::poll_result_t           step_res;
    logic                              advance;
    logic                              in_fire;
    logic                              cfg_fire;

    assign advance   = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready  = ~in_valid_reg | advance;
    assign in_fire   = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    sbpmr_step u_step
    (
        .cur        (state_reg),
        .pin_levels (in_pins_reg),
        .report     (in_report_reg),
        .nxt        (state_next),
        .res        (step_res)
    );

    // input request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_pins_reg   <= s_tdata[sbpmr_pkg::PIN_W-1:0];
            in_report_reg <= s_tdata[sbpmr_pkg::PIN_W];
        end
    end

    // poll state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbpmr_pkg::STATE_RESET;
        end
        else if (cfg_fire)
        begin
            state_reg.remap_active <= cfg_data;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

    `SBPMR_ASSERT(a_toggle_flips_mode,
        advance && step_res.remap_toggled |=>
            state_reg.remap_active != $past(state_reg.remap_active),
        "remap toggle did not flip remap mode")
    `SBPMR_ASSERT(a_select_alternates,
        advance && !cfg_fire |=> state_reg.select_high != $past(state_reg.select_high),
        "select level did not alternate on a poll step")
    `SBPMR_ASSERT(a_skip_range,
        state_reg.skip_count != 2'd3,
        "skip count out of range")
    `SBPMR_ASSERT(a_ready_when_drained,
        !out_valid_reg |-> s_tready,
        "input stalled with empty result register")

endmodule
